### sv/fdl_pkg.sv
// fdl_pkg: shared widths, types and codes for the fractional delay line
// no dependencies
`default_nettype none

package fdl_pkg;

    localparam int DEPTH       = 4096;
    localparam int STORE_DEPTH = DEPTH + 1;
    localparam int POS_W       = $clog2(DEPTH);
    localparam int LEN_W       = $clog2(DEPTH + 1);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int SR_W        = 18;
    localparam int WL_W        = 13;
    localparam int DT_W        = 20;
    localparam int SMP_W       = 16;
    localparam int FRAC_W      = 8;
    localparam int DLY_SHIFT   = 12;
    localparam int PROD_W      = DT_W + SR_W;
    localparam int DLY_W       = PROD_W - DLY_SHIFT;
    localparam int Q8_W        = LEN_W + FRAC_W;
    localparam int DIFF_W      = SMP_W + 1;
    localparam int MULT_W      = DIFF_W + FRAC_W + 1;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = SR_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SR_W-1:0] SAMPLE_RATE_RESET = SR_W'(48000);
    localparam logic [WL_W-1:0] WRAP_LENGTH_RESET = WL_W'(4096);
    localparam int              WRAP_MIN          = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_WRAP_LENGTH = 1'b1
    } fdl_cfg_idx_e;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } fdl_op_e;

    typedef struct packed {
        fdl_op_e           op;
        logic [DT_W-1:0]   arg;
    } fdl_cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR,
        ST_GUARD,
        ST_MUL,
        ST_SAT,
        ST_ADDR,
        ST_DATA
    } fdl_state_e;

    // wrap length clamped to the usable store range
    function automatic logic [LEN_W-1:0] eff_len(input logic [WL_W-1:0] w);
        logic [LEN_W-1:0] r;
        if (32'(w) < 32'(WRAP_MIN))
            r = LEN_W'(WRAP_MIN);
        else if (32'(w) > 32'(DEPTH))
            r = LEN_W'(DEPTH);
        else
            r = LEN_W'(w);
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/fdl_ifs.sv
// fdl_ifs: handshake channels of the fractional delay line (item, result, config)
// depends on fdl_pkg
`default_nettype none

interface fdl_item_if;
    logic                              valid;
    logic                              ready;
    logic                              op;
    logic signed [fdl_pkg::SMP_W-1:0]  sample;
    logic [fdl_pkg::DT_W-1:0]          delay_time;

    modport source(output valid, op, sample, delay_time, input ready);
    modport sink(input valid, op, sample, delay_time, output ready);
endinterface

interface fdl_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [fdl_pkg::SMP_W-1:0]  delayed_sample;

    modport source(output valid, delayed_sample, input ready);
    modport sink(input valid, delayed_sample, output ready);
endinterface

interface fdl_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fdl_pkg::CFG_IDX_W-1:0]     index;
    logic [fdl_pkg::CFG_DATA_W-1:0]    data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/fdl_ram.sv
// fdl_ram: generic single write port, dual read port ram with registered reads
// no dependencies
`default_nettype none

module fdl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4097
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### sv/fdl_front.sv
// fdl_front: accepts item words, tags them as write or read, queues them
// depends on fdl_pkg and fdl_ifs
`default_nettype none

module fdl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    fdl_item_if.sink               item,
    input  wire logic              clearing,
    output fdl_pkg::fdl_cmd_t      cmd,
    output logic                   cmd_valid,
    input  wire logic              cmd_pop
);

    fdl_pkg::fdl_cmd_t                 q_reg [fdl_pkg::QUEUE_DEPTH];
    logic [fdl_pkg::Q_PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [fdl_pkg::Q_PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [fdl_pkg::Q_CNT_W-1:0]       cnt_reg, cnt_next;
    fdl_pkg::fdl_cmd_t                 cmd_in;
    logic                              push;
    logic                              pop;

    assign item.ready = (cnt_reg != fdl_pkg::Q_CNT_W'(fdl_pkg::QUEUE_DEPTH)) && !clearing;
    assign push       = item.valid && item.ready;
    assign pop        = cmd_pop && cmd_valid;
    assign cmd_valid  = (cnt_reg != '0);
    assign cmd        = q_reg[rd_ptr_reg];

    // classify: writes carry the sample, reads carry the delay time
    always_comb
    begin
        cmd_in.op = fdl_pkg::fdl_op_e'(item.op);
        if (cmd_in.op == fdl_pkg::OP_READ)
            cmd_in.arg = item.delay_time;
        else
            cmd_in.arg = {{(fdl_pkg::DT_W - fdl_pkg::SMP_W){1'b0}}, item.sample};
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            if (wr_ptr_reg == fdl_pkg::Q_PTR_W'(fdl_pkg::QUEUE_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            if (rd_ptr_reg == fdl_pkg::Q_PTR_W'(fdl_pkg::QUEUE_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |-> !pop)
        else $error("fdl_front: pop from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !push)
        else $error("fdl_front: word accepted during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("fdl_front: queue count lost a push");

endmodule

`default_nettype wire

### sv/fdl_back.sv
// fdl_back: clears the store, executes writes and interpolated reads, holds the result
// depends on fdl_pkg, fdl_ifs and fdl_ram
`default_nettype none

module fdl_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fdl_pkg::fdl_cmd_t             cmd,
    input  wire logic                          cmd_valid,
    output logic                               cmd_pop,
    input  wire logic [fdl_pkg::SR_W-1:0]      sample_rate,
    input  wire logic [fdl_pkg::LEN_W-1:0]     len,
    output logic                               clearing,
    fdl_result_if.source                       result
);

    fdl_pkg::fdl_state_e                   state_reg, state_next;
    logic [fdl_pkg::LEN_W-1:0]             clr_cnt_reg;
    logic [fdl_pkg::POS_W-1:0]             pos_reg;
    logic                                  out_valid_reg;
    logic signed [fdl_pkg::SMP_W-1:0]      out_data_reg;

    logic [fdl_pkg::DT_W-1:0]              arg_reg;
    logic [fdl_pkg::DLY_W-1:0]             prod_reg;
    logic [fdl_pkg::Q8_W-1:0]              dsat_reg;
    logic [fdl_pkg::ADDR_W-1:0]            ipos_reg;
    logic [fdl_pkg::FRAC_W-1:0]            frac_reg;

    logic [fdl_pkg::POS_W-1:0]             pos_eff;
    logic [fdl_pkg::LEN_W-1:0]             pos_inc;
    logic [fdl_pkg::POS_W-1:0]             pos_wrap;
    logic [fdl_pkg::PROD_W-1:0]            prod;
    logic [fdl_pkg::Q8_W-1:0]              len_q8;
    logic [fdl_pkg::Q8_W-1:0]              pos_q8;
    logic [fdl_pkg::Q8_W-1:0]              dsat;
    logic [fdl_pkg::Q8_W-1:0]              rd;
    logic [fdl_pkg::ADDR_W-1:0]            ra;
    logic [fdl_pkg::ADDR_W-1:0]            rb;
    logic [fdl_pkg::SMP_W-1:0]             rdata_a;
    logic [fdl_pkg::SMP_W-1:0]             rdata_b;
    logic signed [fdl_pkg::DIFF_W-1:0]     diff;
    logic signed [fdl_pkg::MULT_W-1:0]     mult;
    logic signed [fdl_pkg::MULT_W-1:0]     step;
    logic [fdl_pkg::SMP_W-1:0]             res;

    logic                                  ram_we;
    logic [fdl_pkg::ADDR_W-1:0]            ram_waddr;
    logic [fdl_pkg::SMP_W-1:0]             ram_wdata;
    logic                                  out_free;
    logic                                  out_load;

    // write position, treated as zero when stale after a shorter wrap
    assign pos_eff  = (fdl_pkg::LEN_W'(pos_reg) >= len) ? '0 : pos_reg;
    assign pos_inc  = fdl_pkg::LEN_W'(pos_eff) + 1'b1;
    assign pos_wrap = (pos_inc >= len) ? '0 : pos_inc[fdl_pkg::POS_W-1:0];

    // delay in samples, q.8
    assign prod   = fdl_pkg::PROD_W'(arg_reg) * fdl_pkg::PROD_W'(sample_rate);
    assign len_q8 = {len, fdl_pkg::FRAC_W'(0)};
    assign pos_q8 = fdl_pkg::Q8_W'({pos_eff, fdl_pkg::FRAC_W'(0)});
    assign dsat   = (prod_reg > fdl_pkg::DLY_W'(len_q8)) ? len_q8
                                                         : prod_reg[fdl_pkg::Q8_W-1:0];
    assign rd     = (dsat_reg > pos_q8) ? (pos_q8 + len_q8 - dsat_reg)
                                        : (pos_q8 - dsat_reg);

    assign ra = (state_reg == fdl_pkg::ST_ADDR) ? rd[fdl_pkg::Q8_W-1:fdl_pkg::FRAC_W]
                                                : ipos_reg;
    assign rb = ra + 1'b1;

    // linear interpolation with floor
    assign diff = fdl_pkg::DIFF_W'(signed'(rdata_b)) - fdl_pkg::DIFF_W'(signed'(rdata_a));
    assign mult = fdl_pkg::MULT_W'(diff) * signed'({1'b0, frac_reg});
    assign step = mult >>> fdl_pkg::FRAC_W;
    assign res  = rdata_a + step[fdl_pkg::SMP_W-1:0];

    assign out_free = !out_valid_reg || result.ready;
    assign result.valid          = out_valid_reg;
    assign result.delayed_sample = out_data_reg;

    fdl_ram #(
        .WIDTH (fdl_pkg::SMP_W),
        .DEPTH (fdl_pkg::STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ra),
        .raddr_b (rb),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fdl_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == fdl_pkg::LEN_W'(fdl_pkg::DEPTH))
                    state_next = fdl_pkg::ST_IDLE;
            end
            fdl_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.op == fdl_pkg::OP_READ)
                        state_next = fdl_pkg::ST_MUL;
                    else
                        state_next = fdl_pkg::ST_WR;
                end
            end
            fdl_pkg::ST_WR:
            begin
                if (pos_eff == '0)
                    state_next = fdl_pkg::ST_GUARD;
                else
                    state_next = fdl_pkg::ST_IDLE;
            end
            fdl_pkg::ST_GUARD: state_next = fdl_pkg::ST_IDLE;
            fdl_pkg::ST_MUL:   state_next = fdl_pkg::ST_SAT;
            fdl_pkg::ST_SAT:   state_next = fdl_pkg::ST_ADDR;
            fdl_pkg::ST_ADDR:  state_next = fdl_pkg::ST_DATA;
            fdl_pkg::ST_DATA:
            begin
                if (out_free)
                    state_next = fdl_pkg::ST_IDLE;
            end
            default: state_next = fdl_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        clearing  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = clr_cnt_reg;
        ram_wdata = '0;
        out_load  = 1'b0;
        unique case (state_reg)
            fdl_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
                ram_we   = 1'b1;
            end
            fdl_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
            end
            fdl_pkg::ST_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = fdl_pkg::ADDR_W'(pos_eff);
                ram_wdata = arg_reg[fdl_pkg::SMP_W-1:0];
            end
            fdl_pkg::ST_GUARD:
            begin
                ram_we    = 1'b1;
                ram_waddr = len;
                ram_wdata = arg_reg[fdl_pkg::SMP_W-1:0];
            end
            fdl_pkg::ST_DATA:
            begin
                out_load = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fdl_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fdl_pkg::ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (state_reg == fdl_pkg::ST_WR)
                pos_reg <= pos_wrap;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
            arg_reg <= cmd.arg;
        if (state_reg == fdl_pkg::ST_MUL)
            prod_reg <= prod[fdl_pkg::PROD_W-1:fdl_pkg::DLY_SHIFT];
        if (state_reg == fdl_pkg::ST_SAT)
            dsat_reg <= dsat;
        if (state_reg == fdl_pkg::ST_ADDR)
        begin
            ipos_reg <= rd[fdl_pkg::Q8_W-1:fdl_pkg::FRAC_W];
            frac_reg <= rd[fdl_pkg::FRAC_W-1:0];
        end
        if (out_load)
            out_data_reg <= res;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdl_pkg::ST_CLEAR) |-> !cmd_pop)
        else $error("fdl_back: command taken during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fdl_pkg::ST_DATA))
        else $error("fdl_back: result raised outside data state");

    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == fdl_pkg::ST_CLEAR || state_reg == fdl_pkg::ST_WR
                    || state_reg == fdl_pkg::ST_GUARD))
        else $error("fdl_back: store written outside a write state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fdl_pkg::ST_DATA && $past(state_reg == fdl_pkg::ST_DATA))
            |-> $stable(ra))
        else $error("fdl_back: read address moved while result stalled");

endmodule

`default_nettype wire

### sv/fractional_delay_line.sv
// fractional delay line: a read is queued, then occupies the execution unit in idle, mul,
// sat, addr and data (held in data while the result stalls), a write in idle and wr
// (plus guard at position zero for the guard entry), set by the sequencer and the single
// store write port; after reset a clearing pass zeroes all DEPTH+1 entries, item.ready low;
// config writes are taken at any time through a two-register write channel
// depends on fdl_pkg, fdl_ifs, fdl_front, fdl_back, fdl_ram
`default_nettype none

module fractional_delay_line (
    input  wire logic       clk,
    input  wire logic       rst_n,
    fdl_item_if.sink        item,
    fdl_result_if.source    result,
    fdl_cfg_if.sink         cfg
);

    logic [fdl_pkg::SR_W-1:0]    sample_rate_reg;
    logic [fdl_pkg::WL_W-1:0]    wrap_length_reg;
    logic [fdl_pkg::LEN_W-1:0]   len;
    fdl_pkg::fdl_cmd_t           cmd;
    logic                        cmd_valid;
    logic                        cmd_pop;
    logic                        clearing;

    assign cfg.ready = 1'b1;
    assign len       = fdl_pkg::eff_len(wrap_length_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= fdl_pkg::SAMPLE_RATE_RESET;
            wrap_length_reg <= fdl_pkg::WRAP_LENGTH_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (fdl_pkg::fdl_cfg_idx_e'(cfg.index))
                fdl_pkg::CFG_SAMPLE_RATE: sample_rate_reg <= cfg.data[fdl_pkg::SR_W-1:0];
                fdl_pkg::CFG_WRAP_LENGTH: wrap_length_reg <= cfg.data[fdl_pkg::WL_W-1:0];
                default:                  sample_rate_reg <= sample_rate_reg;
            endcase
        end
    end

    fdl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .clearing  (clearing),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    fdl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cmd_valid   (cmd_valid),
        .cmd_pop     (cmd_pop),
        .sample_rate (sample_rate_reg),
        .len         (len),
        .clearing    (clearing),
        .result      (result)
    );

endmodule

`default_nettype wire

### sim/fractional_delay_line_test.sv
`timescale 1ns / 1ps
// fractional_delay_line_test: self-checking bench for the interpolating delay line
// drives write and read words, sweeps both registers, checks reads against a local predictor
// depends on fdl_pkg, fdl_ifs and fractional_delay_line

module fractional_delay_line_test;

    localparam int STALL_LIMIT   = 20000;
    localparam int ITEMS_PER_SET = 85;
    localparam int NUM_SETS      = 10;
    localparam int NUM_ROWS      = 18;

    typedef struct packed {
        fdl_pkg::fdl_op_e              op;
        logic [fdl_pkg::SMP_W-1:0]     smp;
        logic [fdl_pkg::DT_W-1:0]      dly;
        logic                          known;
        logic [fdl_pkg::SMP_W-1:0]     known_val;
    } stim_row_t;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{fdl_pkg::OP_READ,  16'h0000, 20'h00000, 1'b1, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'hFFFFF, 1'b1, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'h7FFF, 20'h00000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'h8000, 20'hFFFFF, 1'b0, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'h0000, 20'h00000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'hFFFF, 20'h00000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'h0001, 20'h00000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'h5555, 20'h00000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_WRITE, 16'hAAAA, 20'h00000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h00001, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h00016, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h0002C, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h00042, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h00057, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h0006E, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'h00096, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'hFFFF, 20'h80000, 1'b0, 16'h0000},
        '{fdl_pkg::OP_READ,  16'h0000, 20'hFFFFF, 1'b0, 16'h0000}
    };

    localparam logic [fdl_pkg::SR_W-1:0] SET_RATES [NUM_SETS] = '{
        18'd48000, 18'd192000, 18'd8000, 18'd262143, 18'd0,
        18'd44100, 18'd96000, 18'd48000, 18'd123457, 18'd1
    };
    localparam logic [fdl_pkg::WL_W-1:0] SET_WRAPS [NUM_SETS] = '{
        13'd4096, 13'd16, 13'd2, 13'd0, 13'd4096,
        13'd4097, 13'd8191, 13'd3, 13'd100, 13'd1
    };

    logic clk;
    logic rst_n;

    fdl_item_if   item_ch ();
    fdl_result_if result_ch ();
    fdl_cfg_if    cfg_ch ();

    fractional_delay_line i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    logic [fdl_pkg::SMP_W-1:0] line_mem [0:fdl_pkg::DEPTH];
    logic [fdl_pkg::POS_W-1:0] wr_pos;
    logic [fdl_pkg::SR_W-1:0]  cur_rate;
    logic [fdl_pkg::WL_W-1:0]  cur_wrap;

    logic [fdl_pkg::SMP_W-1:0] pending_samples [$];

    int  mismatches;
    int  writes_sent;
    int  reads_sent;
    int  results_checked;
    int  idle_cycles;
    int  ready_hold;
    bit  steady;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic int active_len();
        if (cur_wrap < 13'd2)
            return 2;
        else if (cur_wrap > 13'(fdl_pkg::DEPTH))
            return fdl_pkg::DEPTH;
        else
            return int'(cur_wrap);
    endfunction

    // applies one word to the predictor, returns 1 when it yields a sample
    function automatic bit advance_line(input fdl_pkg::fdl_op_e op,
                                        input logic [fdl_pkg::SMP_W-1:0] smp,
                                        input logic [fdl_pkg::DT_W-1:0] dly,
                                        output logic [fdl_pkg::SMP_W-1:0] out_smp);
        int unsigned len;
        int unsigned pos;
        longint unsigned delay_q8;
        longint unsigned len_q8;
        longint unsigned pos_q8;
        longint unsigned rd;
        int unsigned ipos;
        int frac;
        int prev_v;
        int next_v;
        len = active_len();
        pos = wr_pos;
        out_smp = '0;
        if (pos >= len)
            pos = 0;
        if (op == fdl_pkg::OP_WRITE)
        begin
            line_mem[pos] = smp;
            if (pos == 0)
                line_mem[len] = smp;
            pos++;
            if (pos >= len)
                pos = 0;
            wr_pos = fdl_pkg::POS_W'(pos);
            return 1'b0;
        end
        delay_q8 = (longint'(dly) * longint'(cur_rate)) >> fdl_pkg::DLY_SHIFT;
        len_q8 = longint'(len) << fdl_pkg::FRAC_W;
        pos_q8 = longint'(pos) << fdl_pkg::FRAC_W;
        if (delay_q8 > len_q8)
            delay_q8 = len_q8;
        if (delay_q8 > pos_q8)
            rd = pos_q8 + len_q8 - delay_q8;
        else
            rd = pos_q8 - delay_q8;
        if (rd >= len_q8)
            rd = rd - len_q8;
        ipos = int'(rd >> fdl_pkg::FRAC_W);
        frac = int'(rd & 64'hFF);
        prev_v = $signed(line_mem[ipos]);
        next_v = $signed(line_mem[ipos + 1]);
        out_smp = fdl_pkg::SMP_W'(prev_v + (((next_v - prev_v) * frac) >>> fdl_pkg::FRAC_W));
        return 1'b1;
    endfunction

    task automatic send_word(input fdl_pkg::fdl_op_e op,
                             input logic [fdl_pkg::SMP_W-1:0] smp,
                             input logic [fdl_pkg::DT_W-1:0] dly, input logic known,
                             input logic [fdl_pkg::SMP_W-1:0] known_val);
        logic [fdl_pkg::SMP_W-1:0] predicted;
        int gap;
        item_ch.valid      <= 1'b1;
        item_ch.op         <= op;
        item_ch.sample     <= smp;
        item_ch.delay_time <= dly;
        do
            @(posedge clk);
        while (!item_ch.ready);
        if (advance_line(op, smp, dly, predicted))
        begin
            pending_samples.push_back(known ? known_val : predicted);
            reads_sent++;
        end
        else
            writes_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drops valid, then holds off until every read has returned
    task automatic drain_reads();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(input logic [fdl_pkg::SR_W-1:0] rate,
                                input logic [fdl_pkg::WL_W-1:0] wrap);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= fdl_pkg::CFG_SAMPLE_RATE;
        cfg_ch.data  <= rate;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cur_rate = rate;
        cfg_ch.index <= fdl_pkg::CFG_WRAP_LENGTH;
        cfg_ch.data  <= fdl_pkg::CFG_DATA_W'(wrap);
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cur_wrap = wrap;
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_word();
        int unsigned cap;
        longint unsigned dt_max;
        logic [fdl_pkg::DT_W-1:0] dly;
        if ($urandom_range(0, 99) < 60)
            send_word(fdl_pkg::OP_WRITE, fdl_pkg::SMP_W'($urandom), fdl_pkg::DT_W'($urandom),
                      1'b0, '0);
        else
        begin
            cap = ($urandom_range(0, 1) == 0) ? active_len() + 1 : 64;
            if (cur_rate == '0 || $urandom_range(0, 3) == 0)
                dt_max = (1 << fdl_pkg::DT_W) - 1;
            else
                dt_max = (longint'(cap) << fdl_pkg::DT_W) / longint'(cur_rate);
            if (dt_max > (1 << fdl_pkg::DT_W) - 1)
                dt_max = (1 << fdl_pkg::DT_W) - 1;
            dly = fdl_pkg::DT_W'($urandom_range(0, int'(dt_max)));
            send_word(fdl_pkg::OP_READ, fdl_pkg::SMP_W'($urandom), dly, 1'b0, '0);
        end
    endtask

    // result side: check against the oldest expected sample, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected delayed_sample, expected none, got %0d",
                         $time, result_ch.delayed_sample);
                mismatches++;
            end
            else
            begin
                if (result_ch.delayed_sample !== pending_samples[0])
                begin
                    $display("%0t: delayed_sample mismatch, expected %0d, got %0d", $time,
                             $signed(pending_samples[0]), result_ch.delayed_sample);
                    mismatches++;
                end
                void'(pending_samples.pop_front());
                results_checked++;
            end
        end
        if (ready_hold > 0)
            ready_hold--;
        else if (steady || $urandom_range(0, 9) < 7)
        begin
            result_ch.ready <= 1'b1;
            ready_hold = $urandom_range(0, 5);
        end
        else
        begin
            result_ch.ready <= 1'b0;
            ready_hold = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        item_ch.valid      = 1'b0;
        item_ch.op         = fdl_pkg::OP_WRITE;
        item_ch.sample     = '0;
        item_ch.delay_time = '0;
        result_ch.ready    = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = fdl_pkg::CFG_SAMPLE_RATE;
        cfg_ch.data        = '0;
        mismatches         = 0;
        writes_sent        = 0;
        reads_sent         = 0;
        results_checked    = 0;
        idle_cycles        = 0;
        ready_hold         = 0;
        steady             = 1'b0;
        for (int i = 0; i <= fdl_pkg::DEPTH; i++)
            line_mem[i] = '0;
        wr_pos   = '0;
        cur_rate = fdl_pkg::SAMPLE_RATE_RESET;
        cur_wrap = fdl_pkg::WRAP_LENGTH_RESET;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values first, directed words, then random words
        for (int r = 0; r < NUM_ROWS; r++)
            send_word(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].smp, DIRECTED_ROWS[r].dly,
                      DIRECTED_ROWS[r].known, DIRECTED_ROWS[r].known_val);

        for (int s = 0; s < NUM_SETS; s++)
        begin
            if (s > 0)
            begin
                drain_reads();
                repeat (10) @(posedge clk);
                write_config(SET_RATES[s], SET_WRAPS[s]);
            end
            steady = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                if ($urandom_range(0, 99) == 0)
                    drain_reads();
                send_random_word();
            end
        end

        drain_reads();
        repeat (20) @(posedge clk);
        $display("covered %0d writes and %0d reads over %0d register settings",
                 writes_sent, reads_sent, NUM_SETS);
        $display("%0d delayed samples checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
